@@ rtl/bpl_pkg.sv @@
// Shared types and constants for the buffer-pool frame manager.
package bpl_pkg;

    localparam int FRAMES = 16;
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    localparam int DB_W    = 8;
    localparam int TABLE_W = 16;
    localparam int PAGE_W  = 32;
    localparam int STAMP_W = 32;
    localparam int OUT_IDX_W = 4;

    // Page request and stamp, broadcast to every cell.
    typedef struct packed {
        logic [DB_W-1:0]    db;
        logic [TABLE_W-1:0] table_id;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } req_t;

    // Search token that walks the chain, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               hit_found;
        logic [IDX_W-1:0]   hit_idx;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic               best_found;
        logic [STAMP_W-1:0] best_age;
        logic [IDX_W-1:0]   best_idx;
        logic               best_dirty;
        logic [DB_W-1:0]    best_db;
        logic [TABLE_W-1:0] best_table;
        logic [PAGE_W-1:0]  best_page;
    } tok_t;

    // Frame update, broadcast to every cell; only the addressed cell applies it.
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic               fill;
        logic               wr;
        logic [DB_W-1:0]    db;
        logic [TABLE_W-1:0] table_id;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } upd_t;

endpackage

@@ rtl/buffer_pool_frame_lru.sv @@
// Top level of the buffer-pool frame manager: request control and the chain of frame cells.
//
// Fully associative pool of FRAMES frames with least-recently-used replacement.
// One request is in work at a time. After a request is accepted, a search token walks
// the chain of frame cells, one cell per cycle, and collects the first tag match, the
// first free frame and the oldest frame. The token's findings are registered as it
// leaves the last cell; then the update for the chosen frame and the result are
// registered together, the result into the output register. The time a request takes
// is set by the token walk through the chain. The next request is taken as soon as the
// result is in the output register, even while that result waits to be taken. The
// frame update and the new result wait while an older result is still stalled.
// Frame numbers above 15 are reported by their low four bits.
module buffer_pool_frame_lru (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // db_id[7:0], table_id[23:8], page_number[55:24]
    input  logic [0:0]  s_tuser,   // is_write[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // frame_index[3:0], victim_db_id[11:4],
                                   // victim_table_id[27:12], victim_page[59:28], zero[63:60]
    output logic [1:0]  m_tuser    // hit[0], writeback[1]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    state_t                          state_reg;
    bpl_pkg::req_t                   req_reg;
    logic                            wr_reg;
    logic [bpl_pkg::STAMP_W-1:0]     counter_reg;
    logic                            start_reg;
    bpl_pkg::tok_t                   tok_start;
    bpl_pkg::tok_t                   fin_reg;
    bpl_pkg::upd_t                   upd_reg;
    logic                            m_tvalid_reg;
    logic [63:0]                     m_tdata_reg;
    logic [1:0]                      m_tuser_reg;

    bpl_pkg::tok_t                   tok [0:bpl_pkg::FRAMES];

    logic [bpl_pkg::IDX_W-1:0]       sel;
    logic                            is_hit;
    logic                            is_fill;
    logic                            wb;
    logic [55:0]                     victim;
    logic [bpl_pkg::IDX_W+3:0]       sel_ext;
    logic                            out_free;

    // Launch an empty token into the chain.
    always_comb begin
        tok_start       = '0;
        tok_start.valid = start_reg;
    end

    assign tok[0] = tok_start;

    for (genvar i = 0; i < bpl_pkg::FRAMES; i++) begin : g_cell
        bpl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (bpl_pkg::IDX_W'(i)),
            .req      (req_reg),
            .upd      (upd_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    // Choose the frame: hit first, then a free frame, then the oldest one.
    always_comb begin
        is_hit  = fin_reg.hit_found;
        is_fill = !fin_reg.hit_found;
        wb      = 1'b0;
        victim  = '0;
        if (fin_reg.hit_found) begin
            sel = fin_reg.hit_idx;
        end else if (fin_reg.free_found) begin
            sel = fin_reg.free_idx;
        end else begin
            sel = fin_reg.best_idx;
            wb  = fin_reg.best_dirty;
            if (fin_reg.best_dirty) begin
                victim = {fin_reg.best_page, fin_reg.best_table, fin_reg.best_db};
            end
        end
    end

    assign sel_ext  = {4'b0000, sel};
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            counter_reg  <= '0;
            start_reg    <= 1'b0;
            upd_reg.en   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            start_reg  <= (state_reg == ST_IDLE) && s_tvalid;
            upd_reg.en <= (state_reg == ST_COMMIT) && out_free;
            if ((state_reg == ST_COMMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg.db       <= s_tdata[7:0];
                        req_reg.table_id <= s_tdata[23:8];
                        req_reg.page     <= s_tdata[55:24];
                        req_reg.stamp    <= counter_reg;
                        wr_reg           <= s_tuser[0];
                        state_reg        <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    // Hold until the token leaves the last cell.
                    if (tok[bpl_pkg::FRAMES].valid) begin
                        fin_reg   <= tok[bpl_pkg::FRAMES];
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        upd_reg.idx      <= sel;
                        upd_reg.fill     <= is_fill;
                        upd_reg.wr       <= wr_reg;
                        upd_reg.db       <= req_reg.db;
                        upd_reg.table_id <= req_reg.table_id;
                        upd_reg.page     <= req_reg.page;
                        upd_reg.stamp    <= counter_reg;
                        counter_reg      <= counter_reg + 1'b1;
                        m_tuser_reg      <= {wb, is_hit};
                        m_tdata_reg      <= {4'b0000, victim, sel_ext[3:0]};
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/bpl_cell.sv @@
// One frame of the pool: holds its tag, flags and stamp and forwards the search token.
module bpl_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [bpl_pkg::IDX_W-1:0]      cell_idx,
    input  bpl_pkg::req_t                  req,
    input  bpl_pkg::upd_t                  upd,
    input  bpl_pkg::tok_t                  tok_in,
    output bpl_pkg::tok_t                  tok_out
);

    logic                              valid_reg;
    logic                              dirty_reg;
    logic [bpl_pkg::DB_W-1:0]          db_reg;
    logic [bpl_pkg::TABLE_W-1:0]       table_reg;
    logic [bpl_pkg::PAGE_W-1:0]        page_reg;
    logic [bpl_pkg::STAMP_W-1:0]       stamp_reg;
    bpl_pkg::tok_t                     tok_reg;
    bpl_pkg::tok_t                     tok_next;
    logic                              match;
    logic [bpl_pkg::STAMP_W-1:0]       age;

    assign match = valid_reg && (db_reg == req.db) && (table_reg == req.table_id)
                   && (page_reg == req.page);
    // Wrapping age against the current access count.
    assign age = req.stamp - stamp_reg;

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid) begin
            if (match && !tok_in.hit_found) begin
                tok_next.hit_found = 1'b1;
                tok_next.hit_idx   = cell_idx;
            end
            if (!valid_reg && !tok_in.free_found) begin
                tok_next.free_found = 1'b1;
                tok_next.free_idx   = cell_idx;
            end
            // Strictly older only, so the lower index keeps a tie.
            if (valid_reg && (!tok_in.best_found || (age > tok_in.best_age))) begin
                tok_next.best_found = 1'b1;
                tok_next.best_age   = age;
                tok_next.best_idx   = cell_idx;
                tok_next.best_dirty = dirty_reg;
                tok_next.best_db    = db_reg;
                tok_next.best_table = table_reg;
                tok_next.best_page  = page_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
        end else if (upd.en && (upd.idx == cell_idx)) begin
            if (upd.fill) begin
                valid_reg <= 1'b1;
                dirty_reg <= upd.wr;
            end else begin
                dirty_reg <= dirty_reg | upd.wr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en && (upd.idx == cell_idx)) begin
            if (upd.fill) begin
                db_reg    <= upd.db;
                table_reg <= upd.table_id;
                page_reg  <= upd.page;
            end
            stamp_reg <= upd.stamp;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/bpl_checker.sv @@
// Port-level checks for the buffer-pool frame manager, bound to the top level.
module bpl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A hit never evicts.
    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("hit reported with writeback");

    // Victim fields are zero unless a dirty frame was evicted.
    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[59:4] == '0) && (m_tdata[63:60] == '0))
        else $error("victim fields set without writeback");

    // One request at a time: busy right after an accept.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken during search");

endmodule

bind buffer_pool_frame_lru bpl_checker u_bpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/buffer_pool_frame_lru_checker.sv @@
// Checker for the buffer-pool frame manager: predicts each request's result and compares it.
module buffer_pool_frame_lru_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // db_id[7:0], table_id[23:8], page_number[55:24]
    input  logic [0:0]  s_tuser,   // is_write[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // frame_index[3:0], victim_db_id[11:4],
                                   // victim_table_id[27:12], victim_page[59:28], zero[63:60]
    input  logic [1:0]  m_tuser,   // hit[0], writeback[1]
    output int          fail_count,
    output int          pending,
    output int          hit_count,
    output int          writeback_count
);

    typedef struct packed {
        logic [bpl_pkg::OUT_IDX_W-1:0] frame_index;
        logic                          hit;
        logic                          writeback;
        logic [bpl_pkg::DB_W-1:0]      victim_db;
        logic [bpl_pkg::TABLE_W-1:0]   victim_table;
        logic [bpl_pkg::PAGE_W-1:0]    victim_page;
    } frame_result_t;

    // Private copy of the pool.
    logic                        pool_valid [bpl_pkg::FRAMES];
    logic                        pool_dirty [bpl_pkg::FRAMES];
    logic [bpl_pkg::DB_W-1:0]    pool_db    [bpl_pkg::FRAMES];
    logic [bpl_pkg::TABLE_W-1:0] pool_table [bpl_pkg::FRAMES];
    logic [bpl_pkg::PAGE_W-1:0]  pool_page  [bpl_pkg::FRAMES];
    logic [bpl_pkg::STAMP_W-1:0] pool_stamp [bpl_pkg::FRAMES];
    logic [bpl_pkg::STAMP_W-1:0] access_count;

    frame_result_t      expected_results [$];

    function automatic frame_result_t access_pool(input logic [bpl_pkg::DB_W-1:0] db,
                                                  input logic [bpl_pkg::TABLE_W-1:0] tbl,
                                                  input logic [bpl_pkg::PAGE_W-1:0] pg,
                                                  input logic wr);
        frame_result_t               res;
        int                          sel;
        logic [bpl_pkg::STAMP_W-1:0] best_age;
        logic [bpl_pkg::STAMP_W-1:0] age;
        res = '0;
        sel = -1;
        for (int i = 0; i < bpl_pkg::FRAMES; i++) begin
            if (sel < 0 && pool_valid[i] && pool_db[i] == db && pool_table[i] == tbl &&
                pool_page[i] == pg)
                sel = i;
        end
        if (sel >= 0) begin
            res.hit = 1'b1;
        end else begin
            for (int i = 0; i < bpl_pkg::FRAMES; i++) begin
                if (sel < 0 && !pool_valid[i])
                    sel = i;
            end
            if (sel < 0) begin
                // pool full: evict the largest age, lowest index on ties
                sel      = 0;
                best_age = access_count - pool_stamp[0];
                for (int i = 1; i < bpl_pkg::FRAMES; i++) begin
                    age = access_count - pool_stamp[i];
                    if (age > best_age) begin
                        best_age = age;
                        sel      = i;
                    end
                end
                if (pool_dirty[sel]) begin
                    res.writeback    = 1'b1;
                    res.victim_db    = pool_db[sel];
                    res.victim_table = pool_table[sel];
                    res.victim_page  = pool_page[sel];
                end
            end
            pool_valid[sel] = 1'b1;
            pool_dirty[sel] = 1'b0;
            pool_db[sel]    = db;
            pool_table[sel] = tbl;
            pool_page[sel]  = pg;
        end
        if (wr)
            pool_dirty[sel] = 1'b1;
        pool_stamp[sel]   = access_count;
        access_count      = access_count + 1'b1;
        res.frame_index   = bpl_pkg::OUT_IDX_W'(sel);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        frame_result_t want;
        frame_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < bpl_pkg::FRAMES; i++) begin
                pool_valid[i] = 1'b0;
                pool_dirty[i] = 1'b0;
                pool_db[i]    = '0;
                pool_table[i] = '0;
                pool_page[i]  = '0;
                pool_stamp[i] = '0;
            end
            access_count = '0;
            expected_results.delete();
            fail_count      = 0;
            hit_count       = 0;
            writeback_count = 0;
        end else begin
            // a result leaving this cycle belongs to an older request, so check it first
            if (m_tvalid && m_tready) begin
                got.frame_index  = m_tdata[3:0];
                got.victim_db    = m_tdata[11:4];
                got.victim_table = m_tdata[27:12];
                got.victim_page  = m_tdata[59:28];
                got.hit          = m_tuser[0];
                got.writeback    = m_tuser[1];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %s %0d hit %0b wb %0b",
                             $time, "frame", got.frame_index, got.hit, got.writeback);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("writeback", 32'(want.writeback), 32'(got.writeback));
                    check_field("victim_db_id", 32'(want.victim_db), 32'(got.victim_db));
                    check_field("victim_table_id", 32'(want.victim_table),
                                32'(got.victim_table));
                    check_field("victim_page", want.victim_page, got.victim_page);
                    if (want.hit)
                        hit_count++;
                    if (want.writeback)
                        writeback_count++;
                end
            end
            if (s_tvalid && s_tready)
                expected_results = {expected_results,
                                    access_pool(s_tdata[7:0], s_tdata[23:8],
                                                s_tdata[55:24], s_tuser[0])};
        end
        pending = expected_results.size();
    end

endmodule

@@ dv/buffer_pool_frame_lru_tb.sv @@
// Testbench top for the buffer-pool frame manager: clock, reset, page requests and verdict.
module buffer_pool_frame_lru_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 270;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    int          fail_count;
    int          pending;
    int          hit_count;
    int          writeback_count;
    int          sent_count;

    logic        idle_on;
    logic        s_taken;
    logic        m_taken;
    logic [55:0] working_set [$];

    buffer_pool_frame_lru i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    buffer_pool_frame_lru_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending         (pending),
        .hit_count       (hit_count),
        .writeback_count (writeback_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Handshake flags, registered so the driver reads them at the falling edge.
    always_ff @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        m_taken <= m_tvalid && m_tready;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = !(idle_on && $urandom_range(0, 99) < 25);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(negedge aclk);
            if (s_taken || m_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Random tag; now and then a neighbor of a working-set tag with one field changed.
    function automatic logic [55:0] make_tag();
        logic [55:0] tag;
        tag = {32'($urandom), 16'($urandom), 8'($urandom)};
        if (working_set.size() != 0 && $urandom_range(0, 3) == 0) begin
            tag = working_set[$urandom_range(0, working_set.size() - 1)];
            case ($urandom_range(0, 2))
                0:       tag[7:0]   = 8'($urandom);
                1:       tag[23:8]  = 16'($urandom);
                default: tag[55:24] = 32'($urandom);
            endcase
        end
        return tag;
    endfunction

    task automatic send_page(input logic [7:0] db, input logic [15:0] tbl,
                             input logic [31:0] pg, input logic wr);
        while (idle_on && $urandom_range(0, 99) < 25)
            @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {pg, tbl, db};
        s_tuser  = wr;
        do
            @(negedge aclk);
        while (!s_taken);
        s_tvalid = 1'b0;
        sent_count++;
    endtask

    initial begin : stimulus
        logic [55:0] tag;
        int          set_size;
        int          write_pct;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        aresetn    = 1'b0;
        idle_on    = 1'b1;
        sent_count = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // all-zero tag must miss, since every frame is invalid after reset
        send_page(8'h00, 16'h0000, 32'h0000_0000, 1'b0);
        send_page(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_page(8'h00, 16'h0000, 32'h0000_0000, 1'b1);
        send_page(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        // fill the pool, starting with tags that match the zero tag in two fields
        send_page(8'h00, 16'h0000, 32'h0000_0001, 1'b0);
        send_page(8'h01, 16'h0000, 32'h0000_0000, 1'b1);
        send_page(8'h00, 16'h0001, 32'h0000_0000, 1'b0);
        for (int k = 5; k < bpl_pkg::FRAMES; k++)
            send_page(8'(k), 16'(k * 257), 32'(k << 20) | 32'(k), 1'(k));
        // evictions: dirty with zero victim, dirty with all-ones victim
        send_page(8'h80, 16'h8000, 32'h8000_0000, 1'b0);
        send_page(8'h7F, 16'h7FFF, 32'h7FFF_FFFF, 1'b0);
        // refresh the oldest frame so the next misses skip it
        send_page(8'h00, 16'h0000, 32'h0000_0001, 1'b0);
        send_page(8'h55, 16'hAAAA, 32'h5555_AAAA, 1'b1);
        send_page(8'hAA, 16'h5555, 32'hAAAA_5555, 1'b0);
        send_page(8'h00, 16'h0000, 32'h0000_0000, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin set_size = 6;  write_pct = 50; end
                1:       begin set_size = 18; write_pct = 30; end
                2:       begin set_size = 40; write_pct = 80; end
                default: begin set_size = 0;  write_pct = 50; end
            endcase
            // phase 1 runs without any idling on either side
            idle_on = (phase != 1);
            if (phase == 2) begin
                while (pending != 0)
                    @(negedge aclk);
            end
            working_set.delete();
            for (int k = 0; k < set_size; k++)
                working_set = {working_set, make_tag()};
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (working_set.size() != 0 && $urandom_range(0, 99) < 80)
                    tag = working_set[$urandom_range(0, working_set.size() - 1)];
                else
                    tag = make_tag();
                send_page(tag[7:0], tag[23:8], tag[55:24], $urandom_range(0, 99) < write_pct);
            end
        end

        while (pending != 0)
            @(negedge aclk);
        repeat (2 * bpl_pkg::FRAMES + 8) @(negedge aclk);

        $display("Requests sent: %0d, hits %0d, misses %0d, dirty write-backs %0d",
                 sent_count, hit_count, sent_count - hit_count, writeback_count);
        $display("Covered reset-tag misses, partial tag matches, LRU refresh,");
        $display("and phases with and without idling and stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bpl_pkg.sv
rtl/bpl_cell.sv
rtl/buffer_pool_frame_lru.sv
rtl/bpl_checker.sv
dv/buffer_pool_frame_lru_checker.sv
dv/buffer_pool_frame_lru_tb.sv
